>>> sv/spq_pkg.sv
// Package for the sorted priority queue: sizes, command and status codes,
// and the packed beat types of the command and result channels. No dependencies.
package spq_pkg;
  localparam int CAPACITY = 32;
  localparam int KEY_BITS = 16;
  localparam int PRIO_BITS = 16;
  localparam int IDX_BITS = $clog2(CAPACITY);
  localparam int CNT_BITS = $clog2(CAPACITY + 1);
  localparam int ENTRY_BITS = KEY_BITS + PRIO_BITS;

  typedef enum logic [2:0] {
    MODE_INSERT    = 3'd0,
    MODE_POP       = 3'd1,
    MODE_REMOVE    = 3'd2,
    MODE_CHANGE    = 3'd3,
    MODE_CONTAINS  = 3'd4,
    MODE_READ_FIRST = 3'd5,
    MODE_READ_NEXT = 3'd6,
    MODE_CLEAR     = 3'd7
  } mode_t;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_MISSING = 2'd2;

  typedef struct packed {
    logic [2:0]           mode;
    logic [KEY_BITS-1:0]  element;
    logic [PRIO_BITS-1:0] priority_req;
    logic [PRIO_BITS-1:0] priority_new;
  } cmd_t;

  typedef struct packed {
    logic [1:0]           status;
    logic                 found;
    logic                 out_valid;
    logic [KEY_BITS-1:0]  out_element;
    logic [PRIO_BITS-1:0] out_priority;
    logic [5:0]           occupancy;
  } rsp_t;
endpackage

>>> sv/spq_ram.sv
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module spq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

>>> sv/sorted_priority_queue.sv
// Sorted priority queue: keeps up to CAPACITY element and priority pairs in one
// entry RAM (spq_ram), sorted by descending priority, with types from spq_pkg.
// One command runs at a time: a command beat is taken when start is high and
// busy is low, and busy stays high until the result beat, which sits on out_rsp
// for the one cycle marked by out_strobe, the first cycle with busy low; the
// receiver cannot stall it. A command walks the RAM one entry at a time, scanning
// or moving each entry in turn; change priority removes the entry and then
// reinserts it.
module sorted_priority_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  spq_pkg::cmd_t in_cmd,
  output logic          out_strobe,
  output spq_pkg::rsp_t out_rsp
);
  import spq_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_FIND, S_DROP, S_INS, S_SHIFT, S_READ, S_DONE
  } state_t;

  state_t state_r;
  cmd_t cmd_r;
  logic [CNT_BITS-1:0] count_r, idx_r;
  logic [IDX_BITS-1:0] cur_r;
  logic cur_valid_r, busy_r, strobe_r, pend_r, reins_r;
  logic [ENTRY_BITS-1:0] hold_r;
  rsp_t rsp_r;

  logic ram_we;
  logic [IDX_BITS-1:0] ram_addr;
  logic [ENTRY_BITS-1:0] ram_wdata, ram_rdata;
  logic [KEY_BITS-1:0] rd_key;
  logic [PRIO_BITS-1:0] rd_prio, ins_prio;

  assign rd_key = ram_rdata[ENTRY_BITS-1:PRIO_BITS];
  assign rd_prio = ram_rdata[PRIO_BITS-1:0];
  assign ins_prio = reins_r ? cmd_r.priority_new : cmd_r.priority_req;

  spq_ram #(.WIDTH(ENTRY_BITS), .DEPTH(CAPACITY)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wdata), .rdata(ram_rdata)
  );

  // pend_r marks that ram_rdata holds the entry at idx_r read last cycle.
  always_comb begin
    ram_we = 1'b0;
    ram_addr = idx_r[IDX_BITS-1:0];
    ram_wdata = hold_r;
    unique case (state_r)
      S_DROP: begin
        if (pend_r) begin
          ram_we = 1'b1;
          ram_addr = idx_r[IDX_BITS-1:0] - 1'b1;
          ram_wdata = ram_rdata;
        end
      end
      S_SHIFT: begin
        ram_we = 1'b1;
        ram_wdata = hold_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    strobe_r <= 1'b0;
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      cur_r <= '0;
      cur_valid_r <= 1'b0;
      busy_r <= 1'b0;
      pend_r <= 1'b0;
      reins_r <= 1'b0;
    end else begin
      unique case (state_r)
        S_IDLE: begin
          if (start) begin
            cmd_r <= in_cmd;
            busy_r <= 1'b1;
            rsp_r <= '0;
            reins_r <= 1'b0;
            pend_r <= 1'b0;
            idx_r <= '0;
            unique case (in_cmd.mode) inside
              MODE_INSERT: begin
                cur_valid_r <= 1'b0;
                if (count_r == CNT_BITS'(CAPACITY)) begin
                  rsp_r.status <= ST_FULL;
                  state_r <= S_DONE;
                end else state_r <= S_INS;
              end
              MODE_POP: begin
                cur_valid_r <= 1'b0;
                idx_r <= CNT_BITS'(1);
                state_r <= (count_r != '0) ? S_DROP : S_DONE;
              end
              MODE_REMOVE, MODE_CHANGE, MODE_CONTAINS: begin
                if (in_cmd.mode != MODE_CONTAINS) cur_valid_r <= 1'b0;
                state_r <= S_FIND;
              end
              MODE_READ_FIRST: begin
                cur_r <= '0;
                cur_valid_r <= (count_r != '0);
                state_r <= (count_r != '0) ? S_READ : S_DONE;
              end
              MODE_READ_NEXT: begin
                if (cur_valid_r && ({1'b0, cur_r} + 1'b1) < count_r) begin
                  cur_r <= cur_r + 1'b1;
                  idx_r <= CNT_BITS'(cur_r) + 1'b1;
                  state_r <= S_READ;
                end else begin
                  cur_valid_r <= 1'b0;
                  state_r <= S_DONE;
                end
              end
              default: begin
                count_r <= '0;
                cur_valid_r <= 1'b0;
                state_r <= S_DONE;
              end
            endcase
          end
        end
        S_READ: begin
          if (pend_r) begin
            rsp_r.out_valid <= 1'b1;
            rsp_r.out_element <= rd_key;
            rsp_r.out_priority <= rd_prio;
            state_r <= S_DONE;
          end
          pend_r <= ~pend_r;
        end
        S_FIND: begin
          if (pend_r) begin
            if (rd_key == cmd_r.element &&
                (cmd_r.mode != MODE_CHANGE || rd_prio == cmd_r.priority_req)) begin
              pend_r <= 1'b0;
              if (cmd_r.mode == MODE_CONTAINS) begin
                rsp_r.found <= 1'b1;
                state_r <= S_DONE;
              end else begin
                idx_r <= idx_r + 1'b1;
                state_r <= S_DROP;
              end
            end else if (idx_r + 1'b1 >= count_r) begin
              if (cmd_r.mode != MODE_CONTAINS) rsp_r.status <= ST_MISSING;
              state_r <= S_DONE;
            end else begin
              idx_r <= idx_r + 1'b1;
              pend_r <= 1'b0;
            end
          end else if (idx_r >= count_r) begin
            if (cmd_r.mode != MODE_CONTAINS) rsp_r.status <= ST_MISSING;
            state_r <= S_DONE;
          end else pend_r <= 1'b1;
        end
        S_DROP: begin
          if (pend_r) begin
            idx_r <= idx_r + 1'b1;
            pend_r <= 1'b0;
          end else if (idx_r >= count_r) begin
            count_r <= count_r - 1'b1;
            if (cmd_r.mode == MODE_CHANGE) begin
              reins_r <= 1'b1;
              idx_r <= '0;
              state_r <= S_INS;
            end else state_r <= S_DONE;
          end else pend_r <= 1'b1;
        end
        S_INS: begin
          // Find the first slot whose priority is below the new one.
          if (pend_r) begin
            pend_r <= 1'b0;
            if (rd_prio >= ins_prio) idx_r <= idx_r + 1'b1;
            else begin
              hold_r <= {cmd_r.element, ins_prio};
              state_r <= S_SHIFT;
            end
          end else if (idx_r >= count_r) begin
            hold_r <= {cmd_r.element, ins_prio};
            state_r <= S_SHIFT;
          end else pend_r <= 1'b1;
        end
        S_SHIFT: begin
          // Write hold at idx, carry the old entry forward (read returns old data).
          if (pend_r) begin
            pend_r <= 1'b0;
          end else begin
            if (idx_r >= count_r) begin
              count_r <= count_r + 1'b1;
              state_r <= S_DONE;
            end else begin
              pend_r <= 1'b1;
            end
          end
          if (pend_r) begin
            hold_r <= ram_rdata;
            idx_r <= idx_r + 1'b1;
          end
        end
        default: begin
          busy_r <= 1'b0;
          strobe_r <= 1'b1;
          rsp_r.occupancy <= 6'(count_r);
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign busy = busy_r;
  assign out_strobe = strobe_r;
  assign out_rsp = rsp_r;
endmodule

>>> sv/spq_checker.sv
// Port-level checks for the sorted priority queue, bound to the top level.
// Depends on spq_pkg.
module spq_checker (
  input logic          clk,
  input logic          rst_n,
  input logic          start,
  input logic          busy,
  input logic          out_strobe,
  input spq_pkg::rsp_t out_rsp
);
  import spq_pkg::*;

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy) else $error("busy did not rise after accept");
  a_strobe_ends: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !busy) else $error("result while busy");
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe) else $error("double result beat");
  a_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> out_rsp.occupancy <= 6'(CAPACITY)) else $error("occupancy range");
endmodule

bind sorted_priority_queue spq_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_strobe(out_strobe), .out_rsp(out_rsp)
);

>>> dv/tb_sorted_priority_queue.sv
// Testbench for sorted_priority_queue: drives commands through start/busy and
// checks every result strobe against a behavioral model of the sorted list.
// Depends on spq_pkg and the RTL of the queue.
`timescale 1ns / 1ps

module tb_sorted_priority_queue;
  import spq_pkg::*;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  cmd_t in_cmd;
  logic out_strobe;
  rsp_t out_rsp;

  sorted_priority_queue dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_cmd(in_cmd), .out_strobe(out_strobe), .out_rsp(out_rsp)
  );

  logic [KEY_BITS-1:0] list_key [CAPACITY];
  logic [PRIO_BITS-1:0] list_prio [CAPACITY];
  int list_len;
  int walk_pos;
  bit walk_ok;
  rsp_t pending_rsp [$];
  int fail_count;

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  initial begin
    #50ms;
    $display("FAIL");
    $finish;
  end

  function automatic void list_put(logic [KEY_BITS-1:0] k, logic [PRIO_BITS-1:0] p);
    int pos;
    pos = 0;
    while (pos < list_len && list_prio[pos] >= p) pos++;
    for (int i = list_len; i > pos; i--) begin
      list_key[i] = list_key[i-1];
      list_prio[i] = list_prio[i-1];
    end
    list_key[pos] = k;
    list_prio[pos] = p;
    list_len++;
  endfunction

  function automatic void list_drop(int pos);
    for (int i = pos; i + 1 < list_len; i++) begin
      list_key[i] = list_key[i+1];
      list_prio[i] = list_prio[i+1];
    end
    list_len--;
  endfunction

  function automatic int list_find(logic [KEY_BITS-1:0] k, bit by_prio,
                                   logic [PRIO_BITS-1:0] p);
    for (int i = 0; i < list_len; i++)
      if (list_key[i] == k && (!by_prio || list_prio[i] == p)) return i;
    return list_len;
  endfunction

  function automatic rsp_t queue_apply(cmd_t c);
    rsp_t r;
    int pos;
    r = '0;
    case (mode_t'(c.mode))
      MODE_INSERT: begin
        walk_ok = 0;
        if (list_len >= CAPACITY) r.status = ST_FULL;
        else list_put(c.element, c.priority_req);
      end
      MODE_POP: begin
        walk_ok = 0;
        if (list_len > 0) list_drop(0);
      end
      MODE_REMOVE: begin
        walk_ok = 0;
        pos = list_find(c.element, 0, '0);
        if (pos < list_len) list_drop(pos);
        else r.status = ST_MISSING;
      end
      MODE_CHANGE: begin
        walk_ok = 0;
        pos = list_find(c.element, 1, c.priority_req);
        if (pos < list_len) begin
          list_drop(pos);
          list_put(c.element, c.priority_new);
        end else r.status = ST_MISSING;
      end
      MODE_CONTAINS: r.found = list_find(c.element, 0, '0) < list_len;
      MODE_READ_FIRST: begin
        walk_ok = list_len > 0;
        walk_pos = 0;
      end
      MODE_READ_NEXT: begin
        if (walk_ok && walk_pos + 1 < list_len) walk_pos++;
        else walk_ok = 0;
      end
      default: begin
        list_len = 0;
        walk_ok = 0;
      end
    endcase
    if ((c.mode == MODE_READ_FIRST || c.mode == MODE_READ_NEXT) && walk_ok &&
        walk_pos < list_len) begin
      r.out_valid = 1;
      r.out_element = list_key[walk_pos];
      r.out_priority = list_prio[walk_pos];
    end
    r.occupancy = 6'(list_len);
    return r;
  endfunction

  task automatic send_cmd(mode_t m, logic [KEY_BITS-1:0] k,
                          logic [PRIO_BITS-1:0] p, logic [PRIO_BITS-1:0] np);
    cmd_t c;
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      start <= 0;
      in_cmd <= '0;
      repeat (gap) @(posedge clk);
    end
    c.mode = m;
    c.element = k;
    c.priority_req = p;
    c.priority_new = np;
    start <= 1;
    in_cmd <= c;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_rsp.push_back(queue_apply(c));
  endtask

  always @(posedge clk) begin
    rsp_t e;
    if (rst_n && out_strobe) begin
      if (pending_rsp.size() == 0) begin
        $error("result beat with nothing expected");
        fail_count++;
      end else begin
        e = pending_rsp.pop_front();
        if (out_rsp.status !== e.status) begin
          $error("status exp %0d got %0d", e.status, out_rsp.status); fail_count++;
        end
        if (out_rsp.found !== e.found) begin
          $error("found exp %0d got %0d", e.found, out_rsp.found); fail_count++;
        end
        if (out_rsp.out_valid !== e.out_valid) begin
          $error("out_valid exp %0d got %0d", e.out_valid, out_rsp.out_valid);
          fail_count++;
        end
        if (out_rsp.out_element !== e.out_element) begin
          $error("out_element exp %0h got %0h", e.out_element, out_rsp.out_element);
          fail_count++;
        end
        if (out_rsp.out_priority !== e.out_priority) begin
          $error("out_priority exp %0h got %0h", e.out_priority, out_rsp.out_priority);
          fail_count++;
        end
        if (out_rsp.occupancy !== e.occupancy) begin
          $error("occupancy exp %0d got %0d", e.occupancy, out_rsp.occupancy);
          fail_count++;
        end
      end
    end
  end

  task automatic test_extremes();
    send_cmd(MODE_POP, 0, 0, 0);
    send_cmd(MODE_READ_FIRST, 0, 0, 0);
    send_cmd(MODE_READ_NEXT, 0, 0, 0);
    send_cmd(MODE_REMOVE, 16'h1234, 0, 0);
    send_cmd(MODE_CHANGE, 16'h1234, 0, 1);
    send_cmd(MODE_INSERT, 16'hffff, 16'hffff, 0);
    send_cmd(MODE_INSERT, 16'h0000, 16'h0000, 16'hffff);
    send_cmd(MODE_INSERT, 16'haaaa, 16'h5555, 0);
    send_cmd(MODE_INSERT, 16'h5555, 16'h5555, 0);
    send_cmd(MODE_CONTAINS, 16'h5555, 0, 0);
    send_cmd(MODE_CONTAINS, 16'h7777, 0, 0);
    send_cmd(MODE_READ_FIRST, 0, 0, 0);
    for (int i = 0; i < 4; i++) send_cmd(MODE_READ_NEXT, 0, 0, 0);
    send_cmd(MODE_CHANGE, 16'haaaa, 16'h5555, 16'hffff);
    send_cmd(MODE_REMOVE, 16'h0000, 0, 0);
    send_cmd(MODE_READ_NEXT, 0, 0, 0);
    send_cmd(MODE_POP, 0, 0, 0);
    send_cmd(MODE_CLEAR, 0, 0, 0);
  endtask

  task automatic test_full();
    for (int i = 0; i < CAPACITY + 2; i++)
      send_cmd(MODE_INSERT, 16'($urandom), 16'($urandom_range(0, 3)), 0);
    send_cmd(MODE_CHANGE, list_key[5], list_prio[5], 16'hffff);
    send_cmd(MODE_READ_FIRST, 0, 0, 0);
    for (int i = 0; i < CAPACITY; i++) send_cmd(MODE_READ_NEXT, 0, 0, 0);
    send_cmd(MODE_CLEAR, 0, 0, 0);
  endtask

  task automatic test_random();
    int sel;
    int idx;
    logic [KEY_BITS-1:0] k;
    logic [PRIO_BITS-1:0] p;
    for (int n = 0; n < 780; n++) begin
      sel = $urandom_range(0, 99);
      k = $urandom_range(0, 1) ? 16'($urandom_range(0, 15)) : 16'($urandom);
      p = $urandom_range(0, 1) ? 16'($urandom_range(0, 7)) : 16'($urandom);
      idx = list_len > 0 ? $urandom_range(0, list_len - 1) : 0;
      if (sel < 35) send_cmd(MODE_INSERT, k, p, 16'($urandom));
      else if (sel < 43) send_cmd(MODE_POP, k, p, 16'($urandom));
      else if (sel < 52)
        send_cmd(MODE_REMOVE, (list_len > 0 && sel < 49) ? list_key[idx] : k, p, 0);
      else if (sel < 62) begin
        if (list_len > 0 && sel < 59)
          send_cmd(MODE_CHANGE, list_key[idx], list_prio[idx], 16'($urandom));
        else send_cmd(MODE_CHANGE, k, p, 16'($urandom));
      end else if (sel < 70)
        send_cmd(MODE_CONTAINS, (list_len > 0 && sel < 66) ? list_key[idx] : k, p, 0);
      else if (sel < 78) send_cmd(MODE_READ_FIRST, k, p, 16'($urandom));
      else if (sel < 98) send_cmd(MODE_READ_NEXT, k, p, 16'($urandom));
      else send_cmd(MODE_CLEAR, k, p, 16'($urandom));
    end
  endtask

  initial begin
    int wait_cycles;
    rst_n <= 0;
    start <= 0;
    in_cmd <= '0;
    list_len = 0;
    walk_pos = 0;
    walk_ok = 0;
    fail_count = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    test_extremes();
    test_full();
    test_random();
    start <= 0;
    in_cmd <= '0;
    wait_cycles = 0;
    while (pending_rsp.size() > 0 && wait_cycles < 1000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (2 * CAPACITY + 8) @(posedge clk);
    if (fail_count == 0 && pending_rsp.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

>>> filelist.f
sv/spq_pkg.sv
sv/spq_ram.sv
sv/sorted_priority_queue.sv
sv/spq_checker.sv
dv/tb_sorted_priority_queue.sv
